[rtl/core/lsf_pkg.sv]
// Shared widths, types, coefficient tables and helper functions for the shape function core.
package lsf_pkg;

   localparam int NUM_FUNCTIONS = 11;
   localparam int FRAC_BITS     = 16;

   localparam int TABLE_DEPTH  = 11;
   localparam int MAX_TERMS    = 5;
   localparam int HORNER_STEPS = MAX_TERMS - 1;

   localparam int IDX_W = 4;
   localparam int POS_W = 18;
   localparam int OUT_W = 18;
   localparam int ERR_W = 2;

   // Operand width for s and s^2, accumulator width for the polynomial chain.
   localparam int B_W       = (FRAC_BITS + 3 > POS_W) ? FRAC_BITS + 3 : POS_W;
   localparam int ACC_W     = FRAC_BITS + 15;
   localparam int LIN_W     = B_W + 2;
   localparam int WIDE_W    = ACC_W + 3;
   localparam int COEF_W    = 32;
   localparam int SCALE_P_W = ACC_W + COEF_W;
   localparam int SCALE_SHIFT = 30;
   localparam int SHIFT_W   = $clog2(SCALE_SHIFT + 9);

   localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
   localparam logic [ERR_W-1:0] ERR_INDEX    = 2'd1;
   localparam logic [ERR_W-1:0] ERR_POSITION = 2'd2;

   typedef logic signed [ACC_W-1:0] acc_type;
   typedef logic signed [B_W-1:0]   opnd_type;
   typedef logic signed [LIN_W-1:0] lin_type;
   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef logic signed [OUT_W-1:0] out_type;

   typedef struct packed {
      logic [IDX_W-1:0] k;
      logic [ERR_W-1:0] err;
      opnd_type         s;
      opnd_type         s2;
      lin_type          lin;
   } ctrl_type;

   localparam opnd_type OPND_ONE = opnd_type'(1) <<< FRAC_BITS;

   // Horner coefficients of the polynomial in s^2, highest power first.
   localparam int POLY_COEF [TABLE_DEPTH][MAX_TERMS] = '{
      '{0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0},
      '{5, -1, 0, 0, 0},
      '{7, -3, 0, 0, 0},
      '{21, -14, 1, 0, 0},
      '{33, -30, 5, 0, 0},
      '{429, -495, 135, -5, 0},
      '{715, -1001, 385, -35, 0},
      '{2431, -4004, 2002, -308, 7}
   };
   localparam int POLY_LEN   [TABLE_DEPTH] = '{0, 0, 1, 1, 2, 2, 3, 3, 4, 4, 5};
   localparam int DENOM_LOG2 [TABLE_DEPTH] = '{0, 0, 1, 1, 3, 3, 4, 4, 7, 7, 8};

   // Rounded square root of (2k-1) * 2^59, a Q.30 value of sqrt((2k-1)/2).
   function automatic logic [COEF_W-1:0] sqrt_coef(int k);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] bit_v;
      if (k < 2) begin
         return '0;
      end
      x = 64'(2 * k - 1) << 59;
      r = '0;
      bit_v = 64'd1 << 62;
      while (bit_v > x) begin
         bit_v = bit_v >> 2;
      end
      while (bit_v != 64'd0) begin
         if (x >= r + bit_v) begin
            x = x - (r + bit_v);
            r = (r >> 1) + bit_v;
         end else begin
            r = r >> 1;
         end
         bit_v = bit_v >> 2;
      end
      if (x > r) begin
         r = r + 64'd1;
      end
      return r[COEF_W-1:0];
   endfunction

   localparam logic [COEF_W-1:0] SQRT_COEF [TABLE_DEPTH] = '{
      sqrt_coef(0), sqrt_coef(1), sqrt_coef(2), sqrt_coef(3), sqrt_coef(4), sqrt_coef(5),
      sqrt_coef(6), sqrt_coef(7), sqrt_coef(8), sqrt_coef(9), sqrt_coef(10)
   };

   // Integer coefficient n of function k, aligned to the fixed-point grid.
   function automatic acc_type coef_term(logic [IDX_W-1:0] k, int n);
      return acc_type'(POLY_COEF[k][n]) <<< FRAC_BITS;
   endfunction

   localparam wide_type OUT_MAX_V = wide_type'(2 ** (OUT_W - 1) - 1);
   localparam wide_type OUT_MIN_V = wide_type'(-(2 ** (OUT_W - 1)));

   function automatic out_type sat_out(wide_type v);
      if (v > OUT_MAX_V) begin
         return out_type'(OUT_MAX_V);
      end else if (v < OUT_MIN_V) begin
         return out_type'(OUT_MIN_V);
      end
      return out_type'(v);
   endfunction

endpackage

[rtl/core/lsf_front.sv]
// First pipeline stage: range checks, s^2, the linear functions and the Horner seed.
module lsf_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  logic [lsf_pkg::IDX_W-1:0]  basis_index,
   input  logic signed [lsf_pkg::POS_W-1:0] position,
   output logic                       out_valid,
   output lsf_pkg::ctrl_type          out_ctrl,
   output lsf_pkg::acc_type           out_acc
);
   import lsf_pkg::*;

   localparam int SQ_W = 2 * POS_W;
   localparam logic [SQ_W-1:0] SQ_HALF = SQ_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [B_W:0] POS_ONE = (B_W + 1)'(1) <<< FRAC_BITS;
   localparam logic signed [B_W:0] NEG_ONE = -POS_ONE;
   localparam lin_type LIN_ONE = lin_type'(1) <<< FRAC_BITS;

   logic                   valid_ff;
   ctrl_type               ctrl_ff;
   ctrl_type               ctrl_in;
   acc_type                acc_ff;
   acc_type                acc_in;
   logic [POS_W-1:0]       s_mag;
   logic [SQ_W-1:0]        sq;
   logic [SQ_W-1:0]        s2_full;
   logic signed [B_W:0]    s_wide;
   lin_type                s_lin;
   lin_type                lin_sum;

   always_comb begin
      s_mag   = position[POS_W-1] ? POS_W'(-position) : POS_W'(position);
      sq      = SQ_W'(s_mag) * SQ_W'(s_mag);
      s2_full = (sq + SQ_HALF) >> FRAC_BITS;
      s_wide  = (B_W + 1)'(position);
      s_lin   = lin_type'(position);

      ctrl_in.s  = opnd_type'(position);
      ctrl_in.s2 = opnd_type'(s2_full);

      // The index check wins over the position check.
      if (int'(basis_index) >= NUM_FUNCTIONS) begin
         ctrl_in.err = ERR_INDEX;
      end else if (s_wide > POS_ONE || s_wide < NEG_ONE) begin
         ctrl_in.err = ERR_POSITION;
      end else begin
         ctrl_in.err = ERR_NONE;
      end
      ctrl_in.k = (ctrl_in.err == ERR_INDEX) ? '0 : basis_index;

      lin_sum = ctrl_in.k[0] ? LIN_ONE + s_lin + lin_type'(1)
                             : LIN_ONE - s_lin + lin_type'(1);
      ctrl_in.lin = lin_sum >>> 1;

      acc_in = coef_term(ctrl_in.k, 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctrl_ff <= ctrl_in;
         acc_ff  <= acc_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctrl  = ctrl_ff;
   assign out_acc   = acc_ff;

endmodule

[rtl/core/lsf_mac_stage.sv]
// Pipeline stage: signed multiply rounded to the fraction grid plus an addend, or bypass.
module lsf_mac_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  lsf_pkg::ctrl_type in_ctrl,
   input  lsf_pkg::acc_type  in_acc,
   input  logic              step_en,
   input  lsf_pkg::opnd_type op_b,
   input  lsf_pkg::acc_type  addend,
   output logic              out_valid,
   output lsf_pkg::ctrl_type out_ctrl,
   output lsf_pkg::acc_type  out_acc
);
   import lsf_pkg::*;

   localparam int P_W = ACC_W + B_W;
   localparam logic [P_W-1:0] HALF = P_W'(1) << (FRAC_BITS - 1);

   logic             valid_ff;
   ctrl_type         ctrl_ff;
   acc_type          acc_ff;
   acc_type          acc_in;
   logic             neg;
   logic [ACC_W-1:0] a_mag;
   logic [B_W-1:0]   b_mag;
   logic [P_W-1:0]   prod;
   logic [P_W-1:0]   rnd_full;
   acc_type          rnd;
   acc_type          res;

   always_comb begin
      // Rounding is done on magnitudes so that ties go away from zero.
      neg      = in_acc[ACC_W-1] ^ op_b[B_W-1];
      a_mag    = in_acc[ACC_W-1] ? ACC_W'(-in_acc) : ACC_W'(in_acc);
      b_mag    = op_b[B_W-1] ? B_W'(-op_b) : B_W'(op_b);
      prod     = P_W'(a_mag) * P_W'(b_mag);
      rnd_full = (prod + HALF) >> FRAC_BITS;
      rnd      = acc_type'(rnd_full[ACC_W-1:0]);
      res      = neg ? -rnd : rnd;
      acc_in   = step_en ? res + addend : in_acc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctrl_ff <= in_ctrl;
         acc_ff  <= acc_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctrl  = ctrl_ff;
   assign out_acc   = acc_ff;

endmodule

[rtl/core/lsf_scale.sv]
// Last two stages: normalization constant multiply, rounding shift, saturation and result select.
module lsf_scale (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  lsf_pkg::ctrl_type             in_ctrl,
   input  lsf_pkg::acc_type              in_acc,
   output logic                          out_valid,
   output logic signed [lsf_pkg::OUT_W-1:0] out_value,
   output logic [lsf_pkg::ERR_W-1:0]     out_error_code
);
   import lsf_pkg::*;

   logic                   prod_valid_ff;
   ctrl_type               prod_ctrl_ff;
   logic [SCALE_P_W-1:0]   prod_ff;
   logic [SCALE_P_W-1:0]   prod_in;
   logic                   neg_ff;
   logic                   neg_in;
   logic [ACC_W-1:0]       a_mag;

   logic                   valid_ff;
   out_type                value_ff;
   out_type                value_in;
   logic [ERR_W-1:0]       error_ff;

   logic [SHIFT_W-1:0]     sh;
   logic [SCALE_P_W-1:0]   half;
   logic [SCALE_P_W-1:0]   rnd_full;
   wide_type               mag;
   wide_type               val;

   always_comb begin
      neg_in  = in_acc[ACC_W-1];
      a_mag   = in_acc[ACC_W-1] ? ACC_W'(-in_acc) : ACC_W'(in_acc);
      prod_in = SCALE_P_W'(a_mag) * SCALE_P_W'(SQRT_COEF[in_ctrl.k]);
   end

   always_comb begin
      // The shift folds in the power-of-two denominator of each function.
      sh       = SHIFT_W'(SCALE_SHIFT + DENOM_LOG2[prod_ctrl_ff.k]);
      half     = SCALE_P_W'(1) << (sh - SHIFT_W'(1));
      rnd_full = (prod_ff + half) >> sh;
      mag      = wide_type'(rnd_full[WIDE_W-1:0]);
      val      = neg_ff ? -mag : mag;
      if (prod_ctrl_ff.err != ERR_NONE) begin
         value_in = '0;
      end else if (prod_ctrl_ff.k < IDX_W'(2)) begin
         value_in = sat_out(wide_type'(prod_ctrl_ff.lin));
      end else begin
         value_in = sat_out(val);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         valid_ff      <= 1'b0;
      end else if (adv) begin
         prod_valid_ff <= in_valid;
         valid_ff      <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ctrl_ff <= in_ctrl;
         prod_ff      <= prod_in;
         neg_ff       <= neg_in;
         value_ff     <= value_in;
         error_ff     <= prod_ctrl_ff.err;
      end
   end

   assign out_valid      = valid_ff;
   assign out_value      = value_ff;
   assign out_error_code = error_ff;

endmodule

[rtl/core/lobatto_shape_function_eval_core.sv]
// Top level of the Lobatto hierarchic shape function evaluator.
//
// Input channel (req_): a basis index k and a position s in signed Q1.16.
// Result channel (rsp_): the function value in signed Q1.16 and an error
// code (0 ok, 1 index beyond the table, 2 position outside [-1,1]). On an
// error the value is zero.
//
// The datapath is a nine-stage pipeline: a front stage for s^2 and the
// range checks, four Horner stages, one stage for the (s^2-1) factor, one
// for the odd factor s, and two stages for the normalization constant and
// final rounding. Every stage but the last holds one multiplier. One item
// is taken every cycle while the output is not stalled.
//
// The whole pipeline advances when the output register is empty or being
// read, so a stalled receiver freezes every stage in place; req_ready then
// drops in the same cycle. Reset clears all valid bits; the data
// registers are not reset.
module lobatto_shape_function_eval_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lsf_pkg::IDX_W-1:0]         req_basis_index,
   input  logic signed [lsf_pkg::POS_W-1:0]  req_position,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [lsf_pkg::OUT_W-1:0]  rsp_value,
   output logic [lsf_pkg::ERR_W-1:0]         rsp_error_code
);
   import lsf_pkg::*;

   localparam int MAC_STAGES = HORNER_STEPS + 2;

   logic     adv;
   logic     valid_chain [MAC_STAGES+1];
   ctrl_type ctrl_chain  [MAC_STAGES+1];
   acc_type  acc_chain   [MAC_STAGES+1];

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   lsf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_valid),
      .basis_index (req_basis_index),
      .position    (req_position),
      .out_valid   (valid_chain[0]),
      .out_ctrl    (ctrl_chain[0]),
      .out_acc     (acc_chain[0])
   );

   for (genvar j = 0; j < MAC_STAGES; j++) begin : g_mac
      logic     step_en;
      opnd_type op_b;
      acc_type  addend;

      if (j < HORNER_STEPS) begin : g_horner
         assign step_en = (j + 1) < POLY_LEN[ctrl_chain[j].k];
         assign op_b    = ctrl_chain[j].s2;
         assign addend  = coef_term(ctrl_chain[j].k, j + 1);
      end else if (j == HORNER_STEPS) begin : g_bubble
         // Multiply by (s^2 - 1), which vanishes at both ends of the element.
         assign step_en = 1'b1;
         assign op_b    = ctrl_chain[j].s2 - OPND_ONE;
         assign addend  = '0;
      end else begin : g_odd
         assign step_en = ctrl_chain[j].k[0];
         assign op_b    = ctrl_chain[j].s;
         assign addend  = '0;
      end

      lsf_mac_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (valid_chain[j]),
         .in_ctrl   (ctrl_chain[j]),
         .in_acc    (acc_chain[j]),
         .step_en   (step_en),
         .op_b      (op_b),
         .addend    (addend),
         .out_valid (valid_chain[j+1]),
         .out_ctrl  (ctrl_chain[j+1]),
         .out_acc   (acc_chain[j+1])
      );
   end

   lsf_scale u_scale (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .in_valid       (valid_chain[MAC_STAGES]),
      .in_ctrl        (ctrl_chain[MAC_STAGES]),
      .in_acc         (acc_chain[MAC_STAGES]),
      .out_valid      (rsp_valid),
      .out_value      (rsp_value),
      .out_error_code (rsp_error_code)
   );

endmodule

[rtl/core/lsf_port_checker.sv]
// Port-level checker for the shape function core, bound to the top level.
module lsf_port_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [lsf_pkg::IDX_W-1:0]         req_basis_index,
   input logic signed [lsf_pkg::POS_W-1:0]  req_position,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [lsf_pkg::OUT_W-1:0]  rsp_value,
   input logic [lsf_pkg::ERR_W-1:0]         rsp_error_code
);
   import lsf_pkg::*;

   // A result held back by the receiver stays put.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_error_code))
      else $error("result changed while stalled");

   // Any flagged item carries a zero value.
   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_NONE |-> rsp_value == '0)
      else $error("nonzero value on an error item");

   // An empty or draining output register lets the pipeline take a new item.
   a_ready_flow : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input stalled while the output can move");

   // Reset leaves no result pending.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // An item the pipeline cannot take means the output is stalled.
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a stalled output");

endmodule

bind lobatto_shape_function_eval_core lsf_port_checker u_lsf_port_checker (.*);

[dv/lsf_shape_checker.sv]
// Checker for the shape function core: predicts each result and compares it on the rsp_ channel.
module lsf_shape_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [lsf_pkg::IDX_W-1:0]         req_basis_index,
   input  logic signed [lsf_pkg::POS_W-1:0]  req_position,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [lsf_pkg::OUT_W-1:0]  rsp_value,
   input  logic [lsf_pkg::ERR_W-1:0]         rsp_error_code,
   output int                                failures,
   output int                                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = lsf_pkg::FRAC_BITS;
   localparam int CONST_FRAC = 30;
   localparam longint VALUE_MAX = (longint'(1) << (lsf_pkg::OUT_W - 1)) - 1;
   localparam longint VALUE_MIN = -(longint'(1) << (lsf_pkg::OUT_W - 1));

   typedef struct packed {
      logic signed [lsf_pkg::OUT_W-1:0] value;
      logic [lsf_pkg::ERR_W-1:0]        err;
   } psi_result_type;

   // Polynomial in s^2 for each function, leading coefficient first.
   localparam int LOBATTO_POLY [11][5] = '{
      '{0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0},
      '{5, -1, 0, 0, 0},
      '{7, -3, 0, 0, 0},
      '{21, -14, 1, 0, 0},
      '{33, -30, 5, 0, 0},
      '{429, -495, 135, -5, 0},
      '{715, -1001, 385, -35, 0},
      '{2431, -4004, 2002, -308, 7}
   };
   localparam int LOBATTO_TERMS [11] = '{0, 0, 1, 1, 2, 2, 3, 3, 4, 4, 5};
   localparam int DENOM_SHIFT [11] = '{0, 0, 1, 1, 3, 3, 4, 4, 7, 7, 8};

   psi_result_type expected_psi_q[$];
   int mismatch_count = 0;

   assign failures = mismatch_count;
   assign pending  = expected_psi_q.size();

   // Product shifted right with rounding to nearest, ties away from zero.
   function automatic longint round_mul(longint a, longint b, int sh);
      logic [127:0] mag_a;
      logic [127:0] mag_b;
      logic [127:0] prod;
      bit neg;
      neg   = (a < 0) != (b < 0);
      mag_a = (a < 0) ? 128'(-a) : 128'(a);
      mag_b = (b < 0) ? 128'(-b) : 128'(b);
      prod  = (mag_a * mag_b + (128'd1 << (sh - 1))) >> sh;
      return neg ? -longint'(prod[62:0]) : longint'(prod[62:0]);
   endfunction

   // sqrt((2k-1)/2) in Q.30, found bit by bit and rounded to nearest.
   function automatic longint norm_constant(int k);
      logic [127:0] x;
      logic [127:0] r;
      logic [127:0] trial;
      x = 128'(2 * k - 1) << 59;
      r = '0;
      for (int b = 32; b >= 0; b--) begin
         trial = r | (128'd1 << b);
         if (trial * trial <= x) begin
            r = trial;
         end
      end
      if (x - r * r > r) begin
         r = r + 128'd1;
      end
      return longint'(r[62:0]);
   endfunction

   function automatic psi_result_type eval_shape_function(logic [lsf_pkg::IDX_W-1:0] k,
                                                          logic signed [lsf_pkg::POS_W-1:0] pos);
      psi_result_type res;
      longint s;
      longint one;
      longint s2;
      longint acc;
      longint v;
      int kk;
      s   = pos;
      one = longint'(1) << FRAC;
      v   = 0;
      kk  = k;
      res.err = lsf_pkg::ERR_NONE;
      if (kk >= lsf_pkg::NUM_FUNCTIONS) begin
         res.err = lsf_pkg::ERR_INDEX;
      end else if (s > one || s < -one) begin
         res.err = lsf_pkg::ERR_POSITION;
      end else if (kk == 0) begin
         v = (one - s + 1) >>> 1;
      end else if (kk == 1) begin
         v = (one + s + 1) >>> 1;
      end else begin
         s2  = round_mul(s, s, FRAC);
         acc = longint'(LOBATTO_POLY[kk][0]) * one;
         for (int n = 1; n < LOBATTO_TERMS[kk]; n++) begin
            acc = round_mul(acc, s2, FRAC) + longint'(LOBATTO_POLY[kk][n]) * one;
         end
         acc = round_mul(s2 - one, acc, FRAC);
         if (kk % 2 == 1) begin
            acc = round_mul(acc, s, FRAC);
         end
         v = round_mul(acc, norm_constant(kk), CONST_FRAC + DENOM_SHIFT[kk]);
      end
      if (v > VALUE_MAX) begin
         v = VALUE_MAX;
      end else if (v < VALUE_MIN) begin
         v = VALUE_MIN;
      end
      res.value = v[lsf_pkg::OUT_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      psi_result_type want;
      if (reset) begin
         expected_psi_q.delete();
      end else begin
         if (req_valid && req_ready) begin
            expected_psi_q.push_back(eval_shape_function(req_basis_index, req_position));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_psi_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected item: value %0d error_code %0d", $time,
                        rsp_value, rsp_error_code);
            end else begin
               want = expected_psi_q.pop_front();
               if (rsp_value !== want.value) begin
                  mismatch_count++;
                  $display("%0t: value mismatch: expected %0d actual %0d", $time,
                           want.value, rsp_value);
               end
               if (rsp_error_code !== want.err) begin
                  mismatch_count++;
                  $display("%0t: error_code mismatch: expected %0d actual %0d", $time,
                           want.err, rsp_error_code);
               end
            end
         end
      end
   end

endmodule

[dv/tb_lobatto_shape_function_eval_core.sv]
// Top of the shape function core testbench: clock, reset, stimulus and the verdict.
module tb_lobatto_shape_function_eval_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT     = 4000;
   localparam int DRAIN_CYCLES    = 30;
   localparam int ITEMS_PER_PHASE = 140;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [lsf_pkg::IDX_W-1:0]         req_basis_index = '0;
   logic signed [lsf_pkg::POS_W-1:0]  req_position = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic signed [lsf_pkg::OUT_W-1:0]  rsp_value;
   logic [lsf_pkg::ERR_W-1:0]         rsp_error_code;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int quiet_cycles = 0;
   int failures;
   int pending;

   always #10 clock = ~clock;

   lobatto_shape_function_eval_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_basis_index(req_basis_index),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value),
      .rsp_error_code (rsp_error_code)
   );

   lsf_shape_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_basis_index(req_basis_index),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value),
      .rsp_error_code (rsp_error_code),
      .failures       (failures),
      .pending        (pending)
   );

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // The run is abandoned once neither channel has moved an item for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input int k, input int s);
      logic [31:0] noise;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid       <= 1'b0;
         noise            = $urandom;
         req_basis_index <= noise[lsf_pkg::IDX_W-1:0];
         noise            = $urandom;
         req_position    <= noise[lsf_pkg::POS_W-1:0];
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_basis_index <= k[lsf_pkg::IDX_W-1:0];
      req_position    <= s[lsf_pkg::POS_W-1:0];
      do begin
         @(posedge clock);
      end while (!req_ready);
      @(negedge clock);
   endtask

   // Positions inside [-1,1], weighted toward the ends and the middle.
   function automatic int pick_position();
      int s;
      if ($urandom_range(99) < 75) begin
         s = int'($urandom_range(131072)) - 65536;
      end else begin
         case ($urandom_range(8))
            0: s = -65536;
            1: s = -65535;
            2: s = -32768;
            3: s = -1;
            4: s = 0;
            5: s = 1;
            6: s = 32768;
            7: s = 65535;
            default: s = 65536;
         endcase
      end
      return s;
   endfunction

   task automatic send_random_item();
      int roll;
      int k;
      int s;
      roll = $urandom_range(99);
      if (roll < 80) begin
         k = $urandom_range(10);
         s = pick_position();
      end else if (roll < 90) begin
         k = $urandom_range(15, 11);
         s = $urandom;
      end else begin
         k = $urandom_range(10);
         s = $urandom_range(131071, 65537);
         if ($urandom_range(1) == 1) begin
            s = -s - 1;
         end
      end
      send_item(k, s);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Linear functions at both ends and around zero.
      send_item(0, -65536);
      send_item(0, 65536);
      send_item(1, -65536);
      send_item(1, 65536);
      send_item(0, 0);
      send_item(1, -1);
      // Each higher-order function once.
      send_item(2, 32768);
      send_item(3, -20000);
      send_item(4, 65536);
      send_item(5, -65536);
      send_item(6, 0);
      send_item(7, 12345);
      send_item(8, -50000);
      send_item(9, 60000);
      send_item(10, -1);
      // A bad index wins over a bad position.
      send_item(11, 0);
      send_item(15, -131072);
      // Positions just and far outside [-1,1].
      send_item(5, 65537);
      send_item(5, -65537);
      send_item(10, 131071);
      send_item(3, -131072);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 65; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 65; end
            default: begin send_idle_pct = 26; rsp_stall_pct = 26; end
         endcase
         repeat (ITEMS_PER_PHASE) send_random_item();
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
